// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked outside reset only.
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("Assertion failed while out of reset.");

// Property that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("Assertion failed.");

`endif

// File: rtl/core/bte_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap transform engine package
// Image geometry, request codes and the controller command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

   localparam int ICON_SIZE = 16;
   localparam int IDX_WIDTH = $clog2(ICON_SIZE);
   localparam int REQ_WIDTH = 4;

   typedef logic [ICON_SIZE-1:0] row_type;
   typedef row_type [ICON_SIZE-1:0] image_type;

   localparam logic [REQ_WIDTH-1:0] REQ_WRITE  = 4'd0;
   localparam logic [REQ_WIDTH-1:0] REQ_READ   = 4'd1;
   localparam logic [REQ_WIDTH-1:0] REQ_INVERT = 4'd2;
   localparam logic [REQ_WIDTH-1:0] REQ_UP     = 4'd3;
   localparam logic [REQ_WIDTH-1:0] REQ_DOWN   = 4'd4;
   localparam logic [REQ_WIDTH-1:0] REQ_LEFT   = 4'd5;
   localparam logic [REQ_WIDTH-1:0] REQ_RIGHT  = 4'd6;
   localparam logic [REQ_WIDTH-1:0] REQ_MIRROR = 4'd7;
   localparam logic [REQ_WIDTH-1:0] REQ_ROTATE = 4'd8;
   localparam logic [REQ_WIDTH-1:0] REQ_CLEAR  = 4'd9;

   typedef struct packed {
      logic capture;
      logic execute;
      logic fetch;
   } ctl_cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/bte_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap transform engine controller
// Sequences capture, execute and fetch for one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bte_ctrl
   import bte_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   output logic       busy,
   output logic       rsp_valid,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/bte_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap transform engine datapath
// Holds the image and the request, applies one transform, returns a row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bte_datapath
   import bte_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctl_cmd_type          cmd,
   input  wire logic [REQ_WIDTH-1:0] req_type,
   input  wire logic [IDX_WIDTH-1:0] req_row_index,
   input  wire row_type              req_row_data,
   output row_type                   rsp_row_value
);

   logic [REQ_WIDTH-1:0] type_ff;
   logic [IDX_WIDTH-1:0] index_ff;
   row_type              data_ff;
   image_type            rows_ff;
   image_type            rows_in;
   image_type            rotated;
   row_type              value_ff;

   always_comb begin
      for (int j = 0; j < ICON_SIZE; j++) begin
         for (int i = 0; i < ICON_SIZE; i++) begin
            rotated[j][i] = rows_ff[i][ICON_SIZE-1-j];
         end
      end
   end

   always_comb begin
      rows_in = rows_ff;
      unique case (type_ff)
         REQ_WRITE: begin
            rows_in[index_ff] = data_ff;
         end
         REQ_INVERT: begin
            for (int i = 0; i < ICON_SIZE; i++) begin
               rows_in[i] = ~rows_ff[i];
            end
         end
         REQ_UP: begin
            for (int i = 0; i < ICON_SIZE - 1; i++) begin
               rows_in[i] = rows_ff[i+1];
            end
            rows_in[ICON_SIZE-1] = '0;
         end
         REQ_DOWN: begin
            for (int i = 1; i < ICON_SIZE; i++) begin
               rows_in[i] = rows_ff[i-1];
            end
            rows_in[0] = '0;
         end
         REQ_LEFT: begin
            for (int i = 0; i < ICON_SIZE; i++) begin
               rows_in[i] = {rows_ff[i][ICON_SIZE-2:0], 1'b0};
            end
         end
         REQ_RIGHT: begin
            for (int i = 0; i < ICON_SIZE; i++) begin
               rows_in[i] = {1'b0, rows_ff[i][ICON_SIZE-1:1]};
            end
         end
         REQ_MIRROR: begin
            for (int i = 0; i < ICON_SIZE; i++) begin
               for (int k = 0; k < ICON_SIZE; k++) begin
                  rows_in[i][ICON_SIZE-1-k] = rows_ff[i][k];
               end
            end
         end
         REQ_ROTATE: begin
            rows_in = rotated;
         end
         REQ_CLEAR: begin
            rows_in = '0;
         end
         default: begin
            rows_in = rows_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         index_ff <= req_row_index;
         data_ff  <= req_row_data;
      end
      if (cmd.fetch) begin
         value_ff <= rows_ff[index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else if (cmd.execute) begin
         rows_ff <= rows_in;
      end
   end

   assign rsp_row_value = value_ff;

endmodule

`default_nettype wire

// File: rtl/core/bitmap_transform_engine.sv
// ----------------------------------------------------------------------------
// Bitmap transform engine
// A 16x16 one-bit image with row access and whole-image transforms.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. It
// carries an operation code, a row index and row data (used by a write).
// The operations are write row, read, invert, shift rows up or down, shift
// pixels left or right, mirror rows, rotate a quarter turn and clear. Codes
// above clear leave the image alone and act as a read.
// Every request returns one beat: rsp_valid is high for exactly one cycle
// with rsp_row_value holding the addressed row after the operation.
// The request passes through the controller's capture, execute and fetch
// steps around the image register before its beat is shown, and a new
// request can be taken in the same cycle as that beat, so requests do not
// overlap: a new one is taken only once the last one has shown its beat.
// A synchronous reset clears the image and returns the controller to idle.
// The receiver cannot stall; each beat must be taken when it is shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_transform_engine
   import bte_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [REQ_WIDTH-1:0] req_type,
   input  wire logic [IDX_WIDTH-1:0] req_row_index,
   input  wire row_type              req_row_data,
   output logic                      rsp_valid,
   output row_type                   rsp_row_value
);

   ctl_cmd_type cmd;

   bte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bte_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .req_row_data  (req_row_data),
      .rsp_row_value (rsp_row_value)
   );

endmodule

`default_nettype wire

// File: rtl/core/bte_checker.sv
// ----------------------------------------------------------------------------
// Bitmap transform engine checker
// Port-level timing checks on the request and response beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bte_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid))
   `ASSERT_CLKD(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   `ASSERT_CLKD(a_accept_resp, clock, reset, (start && !busy) |-> ##3 rsp_valid)
   `ASSERT_CLKD(a_resp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `ASSERT_CLKD(a_resp_idle, clock, reset, rsp_valid |-> !busy)

endmodule

bind bitmap_transform_engine bte_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
